@@ rtl/core/memory_pattern_self_test_macros.svh @@
// Assertion macros for the memory pattern self-test block.
// Used by the checker module; no other dependencies.
`ifndef MEMORY_PATTERN_SELF_TEST_MACROS_SVH
`define MEMORY_PATTERN_SELF_TEST_MACROS_SVH

// Same-cycle implication, disabled while the reset argument is low
`define MPST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("memory self-test check failed");

// Next-cycle implication, disabled while the reset argument is low
`define MPST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("memory self-test check failed");

`endif

@@ rtl/core/mpst_pkg.sv @@
// Shared types and constants for the memory pattern self-test block.
// No dependencies; used by every module of the block.
package mpst_pkg;

  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 21;
  localparam int CFG_W   = 32;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;
  typedef logic [Q_PTR_W-1:0] q_ptr_t;
  typedef logic [Q_CNT_W-1:0] q_cnt_t;

  // Input request codes
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_RDATA   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_PASS  = 2'd2;
  localparam logic [1:0] KIND_FAIL  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam cnt_t RESET_WORD_COUNT = cnt_t'(512);

  // Classified command passed from front to back
  typedef enum logic [1:0] {
    OP_START,
    OP_ADVANCE,
    OP_RDATA
  } op_t;

  typedef struct packed {
    op_t   op;
    data_t rdata;
  } cmd_t;

endpackage

@@ rtl/core/mpst_front.sv @@
// Front end of the memory self-test: accepts items, classifies them and
// queues commands for the back end. Depends on mpst_pkg.
module mpst_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     in_req_type,
  input  mpst_pkg::data_t in_read_data,
  input  logic           cmd_take,
  output logic           cmd_valid,
  output mpst_pkg::cmd_t cmd
);

  mpst_pkg::cmd_t  q_mem [mpst_pkg::Q_DEPTH];
  mpst_pkg::q_ptr_t wr_ptr_r, wr_ptr_nxt;
  mpst_pkg::q_ptr_t rd_ptr_r, rd_ptr_nxt;
  mpst_pkg::q_cnt_t cnt_r, cnt_nxt;
  mpst_pkg::cmd_t  in_cmd;
  logic            is_cmd;
  logic            enq;
  logic            deq;

  // Classify the item; drop codes that mean nothing
  always_comb begin
    in_cmd.rdata = in_read_data;
    in_cmd.op    = mpst_pkg::OP_START;
    is_cmd       = 1'b1;
    case (in_req_type)
      mpst_pkg::REQ_START:   in_cmd.op = mpst_pkg::OP_START;
      mpst_pkg::REQ_ADVANCE: in_cmd.op = mpst_pkg::OP_ADVANCE;
      mpst_pkg::REQ_RDATA:   in_cmd.op = mpst_pkg::OP_RDATA;
      default:               is_cmd    = 1'b0;
    endcase
  end

  assign full      = (cnt_r == mpst_pkg::q_cnt_t'(mpst_pkg::Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];
  assign enq       = push && !full && is_cmd;
  assign deq       = cmd_take && cmd_valid;

  // Advance pointers; depth is a power of two so they wrap on their own
  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the queued command
  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

@@ rtl/core/mpst_back.sv @@
// Back end of the memory self-test: runs the three test passes, holds the
// configuration registers and the result register. Depends on mpst_pkg.
module mpst_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  mpst_pkg::cfg_data_t  cfg_wdata,
  input  logic                 cmd_valid,
  input  mpst_pkg::cmd_t       cmd,
  output logic                 cmd_take,
  output logic                 res_valid,
  input  logic                 res_pop,
  output logic [1:0]           res_kind,
  output mpst_pkg::addr_t      res_addr,
  output mpst_pkg::data_t      res_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_CHECK_RD,
    PH_CHECK_WR,
    PH_VERIFY
  } phase_t;

  mpst_pkg::addr_t base_r;
  mpst_pkg::cnt_t  count_r;
  phase_t          phase_r, phase_nxt;
  mpst_pkg::cnt_t  offset_r, offset_nxt;
  logic            pending_r, pending_nxt;
  logic            res_valid_r, res_valid_nxt;
  logic [1:0]      res_kind_r, res_kind_nxt;
  mpst_pkg::addr_t res_addr_r, res_addr_nxt;
  mpst_pkg::data_t res_data_r, res_data_nxt;

  logic [mpst_pkg::CNT_W:0] off_inc;
  logic                     last;
  mpst_pkg::cnt_t           off_step;
  mpst_pkg::addr_t          word_addr;
  mpst_pkg::data_t          pat;
  mpst_pkg::data_t          pat_inv;
  logic                     emit;

  // Take a command whenever the result register is free or draining
  assign cmd_take = cmd_valid && (!res_valid_r || res_pop);

  // Address, pattern and end-of-pass for the current word
  always_comb begin
    off_inc   = {1'b0, offset_r} + 1'b1;
    last      = (off_inc >= {1'b0, count_r});
    off_step  = last ? '0 : off_inc[mpst_pkg::CNT_W-1:0];
    word_addr = base_r + mpst_pkg::addr_t'(offset_r);
    pat       = mpst_pkg::data_t'(off_inc);
    pat_inv   = ~pat;
  end

  // Execute one command
  always_comb begin
    phase_nxt    = phase_r;
    offset_nxt   = offset_r;
    pending_nxt  = pending_r;
    emit         = 1'b0;
    res_kind_nxt = res_kind_r;
    res_addr_nxt = res_addr_r;
    res_data_nxt = res_data_r;
    if (cmd_take) begin
      case (cmd.op)
        mpst_pkg::OP_START: begin
          offset_nxt  = '0;
          pending_nxt = 1'b0;
          if (count_r == '0) begin
            phase_nxt    = PH_IDLE;
            emit         = 1'b1;
            res_kind_nxt = mpst_pkg::KIND_PASS;
            res_addr_nxt = '0;
            res_data_nxt = '0;
          end else begin
            phase_nxt = PH_FILL;
          end
        end
        mpst_pkg::OP_ADVANCE: begin
          if (!pending_r) begin
            case (phase_r)
              PH_FILL: begin
                offset_nxt   = off_step;
                phase_nxt    = last ? PH_CHECK_RD : PH_FILL;
                emit         = 1'b1;
                res_kind_nxt = mpst_pkg::KIND_WRITE;
                res_addr_nxt = word_addr;
                res_data_nxt = pat;
              end
              PH_CHECK_WR: begin
                offset_nxt   = off_step;
                phase_nxt    = last ? PH_VERIFY : PH_CHECK_RD;
                emit         = 1'b1;
                res_kind_nxt = mpst_pkg::KIND_WRITE;
                res_addr_nxt = word_addr;
                res_data_nxt = pat_inv;
              end
              PH_CHECK_RD, PH_VERIFY: begin
                pending_nxt  = 1'b1;
                emit         = 1'b1;
                res_kind_nxt = mpst_pkg::KIND_READ;
                res_addr_nxt = word_addr;
                res_data_nxt = '0;
              end
              default: begin
              end
            endcase
          end
        end
        mpst_pkg::OP_RDATA: begin
          if (pending_r) begin
            pending_nxt = 1'b0;
            case (phase_r)
              PH_CHECK_RD: begin
                if (cmd.rdata != pat) begin
                  phase_nxt    = PH_IDLE;
                  offset_nxt   = '0;
                  emit         = 1'b1;
                  res_kind_nxt = mpst_pkg::KIND_FAIL;
                  res_addr_nxt = word_addr;
                  res_data_nxt = '0;
                end else begin
                  phase_nxt = PH_CHECK_WR;
                end
              end
              PH_VERIFY: begin
                if (cmd.rdata != pat_inv) begin
                  phase_nxt    = PH_IDLE;
                  offset_nxt   = '0;
                  emit         = 1'b1;
                  res_kind_nxt = mpst_pkg::KIND_FAIL;
                  res_addr_nxt = word_addr;
                  res_data_nxt = '0;
                end else begin
                  offset_nxt = off_step;
                  if (last) begin
                    phase_nxt    = PH_IDLE;
                    emit         = 1'b1;
                    res_kind_nxt = mpst_pkg::KIND_PASS;
                    res_addr_nxt = '0;
                    res_data_nxt = '0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
    res_valid_nxt = emit || (res_valid_r && !res_pop);
  end

  // Hold state, configuration and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      count_r     <= mpst_pkg::RESET_WORD_COUNT;
      phase_r     <= PH_IDLE;
      offset_r    <= '0;
      pending_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      offset_r    <= offset_nxt;
      pending_r   <= pending_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          mpst_pkg::CFG_BASE:  base_r  <= mpst_pkg::addr_t'(cfg_wdata);
          mpst_pkg::CFG_COUNT: count_r <= cfg_wdata[mpst_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    res_kind_r <= res_kind_nxt;
    res_addr_r <= res_addr_nxt;
    res_data_r <= res_data_nxt;
  end

  assign res_valid = res_valid_r;
  assign res_kind  = res_kind_r;
  assign res_addr  = res_addr_r;
  assign res_data  = res_data_r;

endmodule

@@ rtl/core/memory_pattern_self_test.sv @@
// Top level of the memory pattern self-test block.
// Depends on mpst_pkg, mpst_front and mpst_back.
//
// Usage:
//   Input channel (push/full): in_req_type 0 starts a run, 1 asks for the
//   next memory request, 2 hands back the data word of the pending read.
//   Result channel (empty/pop): write requests, read requests and a final
//   pass or fail word with the failing address.
//   Configuration (cfg_wr_en/cfg_index/cfg_wdata): index 0 base address,
//   index 1 word count; write only while the block is idle.
// Timing:
//   An item accepted into the command queue waits there behind any earlier
//   commands; once the sequencer takes it, its result is loaded into the
//   result register. One item per cycle is sustained while the receiver
//   pops: a two-entry command queue sits between the classifier
//   and the test sequencer, and the result register refills in the cycle
//   it is popped. When the receiver stalls, the result holds, the
//   sequencer stops taking commands and full rises once two items wait.
// Reset: clears the queue, returns to idle, base address 0, word count 512.
module memory_pattern_self_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  mpst_pkg::cfg_data_t cfg_wdata,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_req_type,
  input  mpst_pkg::data_t     in_read_data,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          out_result_kind,
  output mpst_pkg::addr_t     out_address,
  output mpst_pkg::data_t     out_write_data
);

  logic           cmd_valid;
  logic           cmd_take;
  mpst_pkg::cmd_t cmd;
  logic           res_valid;

  // Accept and classify items
  mpst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_req_type  (in_req_type),
    .in_read_data (in_read_data),
    .cmd_take     (cmd_take),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  // Run the test passes and hold the result
  mpst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_kind  (out_result_kind),
    .res_addr  (out_address),
    .res_data  (out_write_data)
  );

  assign empty = !res_valid;

endmodule

@@ rtl/core/mpst_checker.sv @@
// Port-level checks for the memory pattern self-test block, bound to the
// top level. Depends on mpst_pkg and memory_pattern_self_test_macros.svh.
`include "memory_pattern_self_test_macros.svh"

module mpst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input logic [1:0]          out_result_kind,
  input mpst_pkg::addr_t     out_address,
  input mpst_pkg::data_t     out_write_data
);

  logic                                           is_write;
  logic                                           is_pass;
  logic [1+mpst_pkg::ADDR_W+mpst_pkg::DATA_W:0]   out_word;

  assign is_write = (out_result_kind == mpst_pkg::KIND_WRITE);
  assign is_pass  = (out_result_kind == mpst_pkg::KIND_PASS);
  assign out_word = {out_result_kind, out_address, out_write_data};

  // Reset leaves no result waiting
  `MPST_ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, empty)

  // Only write requests carry data
  `MPST_ASSERT_IMPLY(a_no_data, clk, rst_n, !empty && !is_write, out_write_data == '0)

  // A pass result carries a zero address
  `MPST_ASSERT_IMPLY(a_pass_addr, clk, rst_n, !empty && is_pass, out_address == '0)

  // A stalled result holds
  `MPST_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_word))

endmodule

bind memory_pattern_self_test mpst_checker u_mpst_checker (.*);

@@ tb/memory_pattern_self_test_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for memory_pattern_self_test: a directed script, then random runs.
// Popped results are checked against the script or a sequencer model. Depends on mpst_pkg.
module memory_pattern_self_test_test;
  import mpst_pkg::*;

  // Request code the block must ignore
  localparam logic [1:0] REQ_VOID = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_CHECK_RD,
    PH_CHECK_WR,
    PH_VERIFY
  } seq_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    addr_t      addr;
    data_t      wdata;
  } mem_result_t;

  typedef struct packed {
    logic        is_cfg;
    logic        typed;
    logic        has_res;
    logic [1:0]  code;
    data_t       value;
    mem_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_BASE;
  cfg_data_t   cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_req_type = REQ_START;
  data_t       in_read_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_result_kind;
  addr_t       out_address;
  data_t       out_write_data;

  // Model state and register copies
  addr_t       seq_base = '0;
  cnt_t        seq_count = RESET_WORD_COUNT;
  seq_phase_t  seq_phase = PH_IDLE;
  cnt_t        seq_off = '0;
  bit          seq_waiting = 1'b0;

  mem_result_t awaited_outcomes[$];
  int          mismatch_count = 0;
  int          tx_gap_pct = 10;
  int          rx_stall_pct = 10;
  bit          quiet = 1'b0;
  bit          long_hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  memory_pattern_self_test i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_read_data    (in_read_data),
    .empty           (empty),
    .pop             (pop),
    .out_result_kind (out_result_kind),
    .out_address     (out_address),
    .out_write_data  (out_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic data_t word_pattern();
    return data_t'(seq_off) + data_t'(1);
  endfunction

  function automatic data_t any_word();
    return {$urandom, $urandom};
  endfunction

  // Advance to the next word; return 1 when the pass has covered every word
  function automatic bit step_offset();
    logic [CNT_W:0] nxt;
    nxt = {1'b0, seq_off} + 1'b1;
    if (nxt >= {1'b0, seq_count}) begin
      seq_off = '0;
      return 1'b1;
    end
    seq_off = nxt[CNT_W-1:0];
    return 1'b0;
  endfunction

  // Apply one item to the model; return 1 with the result when one is due
  function automatic bit sequencer_step(input logic [1:0] req, input data_t rd,
                                        output mem_result_t res);
    addr_t a;
    data_t pat;
    res = '0;
    a = seq_base + addr_t'(seq_off);
    pat = word_pattern();
    case (req)
      REQ_START: begin
        seq_off = '0;
        seq_waiting = 1'b0;
        if (seq_count == '0) begin
          seq_phase = PH_IDLE;
          res = {KIND_PASS, addr_t'(0), data_t'(0)};
          return 1'b1;
        end
        seq_phase = PH_FILL;
        return 1'b0;
      end
      REQ_ADVANCE: begin
        if (seq_waiting) return 1'b0;
        case (seq_phase)
          PH_FILL: begin
            if (step_offset()) seq_phase = PH_CHECK_RD;
            res = {KIND_WRITE, a, pat};
            return 1'b1;
          end
          PH_CHECK_WR: begin
            seq_phase = step_offset() ? PH_VERIFY : PH_CHECK_RD;
            res = {KIND_WRITE, a, ~pat};
            return 1'b1;
          end
          PH_CHECK_RD, PH_VERIFY: begin
            seq_waiting = 1'b1;
            res = {KIND_READ, a, data_t'(0)};
            return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      REQ_RDATA: begin
        if (!seq_waiting) return 1'b0;
        seq_waiting = 1'b0;
        if (seq_phase == PH_CHECK_RD) begin
          if (rd != pat) begin
            seq_phase = PH_IDLE;
            seq_off = '0;
            res = {KIND_FAIL, a, data_t'(0)};
            return 1'b1;
          end
          seq_phase = PH_CHECK_WR;
          return 1'b0;
        end
        if (seq_phase == PH_VERIFY) begin
          if (rd != ~pat) begin
            seq_phase = PH_IDLE;
            seq_off = '0;
            res = {KIND_FAIL, a, data_t'(0)};
            return 1'b1;
          end
          if (step_offset()) begin
            seq_phase = PH_IDLE;
            res = {KIND_PASS, addr_t'(0), data_t'(0)};
            return 1'b1;
          end
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic script_row_t item_row(logic [1:0] code, data_t value, bit typed);
    script_row_t r;
    r = '0;
    r.code = code;
    r.value = value;
    r.typed = typed;
    return r;
  endfunction

  function automatic script_row_t result_row(logic [1:0] code, data_t value,
                                             logic [1:0] kind, addr_t addr, data_t wdata);
    script_row_t r;
    r = item_row(code, value, 1'b1);
    r.has_res = 1'b1;
    r.want = {kind, addr, wdata};
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic idx, cfg_data_t value);
    script_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.code = {1'b0, idx};
    r.value = data_t'(value);
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Offer one item, hold it until taken, then run it through the model
  task automatic offer_item(input logic [1:0] req, input data_t value, output bit got,
                            output mem_result_t res);
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    in_req_type <= req;
    in_read_data <= value;
    do @(posedge clk); while (full);
    got = sequencer_step(req, value, res);
  endtask

  task automatic offer(input logic [1:0] req, input data_t value);
    bit got;
    mem_result_t res;
    offer_item(req, value, got, res);
    if (got) awaited_outcomes.push_back(res);
  endtask

  // Stop offering, let every awaited result arrive, then let the pipeline settle
  task automatic drain_block();
    push <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input cfg_data_t value);
    cfg_index <= idx;
    cfg_wdata <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BASE) seq_base = addr_t'(value);
    else seq_count = cnt_t'(value);
    @(posedge clk);
  endtask

  // Mostly well-formed test runs with random content, salted with noise
  task automatic run_phase(input int budget);
    int done;
    int pick;
    data_t want;
    done = 0;
    while (done < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        offer(REQ_VOID, any_word());
      end else if (pick < 4) begin
        offer(REQ_RDATA, any_word());
      end else if (pick < 6) begin
        offer(REQ_ADVANCE, any_word());
      end else if (pick < 7) begin
        offer(REQ_START, any_word());
        done++;
      end else begin
        if (seq_phase == PH_IDLE) begin
          offer(REQ_START, any_word());
        end else if (seq_waiting) begin
          want = (seq_phase == PH_VERIFY) ? ~word_pattern() : word_pattern();
          if ($urandom_range(0, 59) == 0) want ^= data_t'(1) << $urandom_range(0, 63);
          offer(REQ_RDATA, want);
        end else begin
          offer(REQ_ADVANCE, any_word());
        end
        done++;
      end
    end
  endtask

  // Check each popped item and decide the next pop
  always @(posedge clk) begin
    mem_result_t want;
    if (rst_n && pop && !empty) begin
      if (awaited_outcomes.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind %0d", out_result_kind));
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_result_kind != want.kind)
          note_mismatch($sformatf("kind %0d, want %0d", out_result_kind, want.kind));
        if (out_address != want.addr)
          note_mismatch($sformatf("address %h, want %h", out_address, want.addr));
        if (out_write_data != want.wdata)
          note_mismatch($sformatf("write data %h, want %h", out_write_data, want.wdata));
      end
    end
    if (quiet) begin
      pop <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 64;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      stall_left = $urandom_range(1, 19) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    script_row_t script[$];
    bit          got;
    mem_result_t res;
    int          phase_no;
    int          sent;
    int          budget;
    int          base_pick;
    int          count_pick;
    cfg_data_t   new_base;
    cfg_data_t   new_count;

    // Directed script, starting from base 0 and 512 words
    script.push_back(item_row(REQ_ADVANCE, '0, 1'b1));          // advance while idle
    script.push_back(item_row(REQ_RDATA, '1, 1'b1));            // read data, none pending
    script.push_back(item_row(REQ_VOID, '1, 1'b0));             // unused request code
    script.push_back(item_row(REQ_START, '0, 1'b1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'd0, 64'd1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'd1, 64'd2));
    script.push_back(item_row(REQ_START, '0, 1'b1));            // restart mid-run
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'd0, 64'd1));
    script.push_back(cfg_row(CFG_COUNT, 32'd0));
    script.push_back(result_row(REQ_START, '0, KIND_PASS, 32'd0, 64'd0));
    script.push_back(item_row(REQ_ADVANCE, '1, 1'b1));
    // Two words at the top of the address space: addresses wrap
    script.push_back(cfg_row(CFG_BASE, 32'hFFFF_FFFF));
    script.push_back(cfg_row(CFG_COUNT, 32'd2));
    script.push_back(item_row(REQ_START, '0, 1'b1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'hFFFF_FFFF, 64'd1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'd0, 64'd2));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_READ, 32'hFFFF_FFFF, 64'd0));
    script.push_back(item_row(REQ_ADVANCE, '0, 1'b0));          // read still pending
    script.push_back(item_row(REQ_RDATA, 64'd1, 1'b1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'hFFFF_FFFF, ~64'd1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_READ, 32'd0, 64'd0));
    script.push_back(item_row(REQ_RDATA, 64'd2, 1'b1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'd0, ~64'd2));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_READ, 32'hFFFF_FFFF, 64'd0));
    script.push_back(item_row(REQ_RDATA, ~64'd1, 1'b1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_READ, 32'd0, 64'd0));
    script.push_back(result_row(REQ_RDATA, ~64'd2, KIND_PASS, 32'd0, 64'd0));
    // One word, top data bit wrong on the check read
    script.push_back(cfg_row(CFG_COUNT, 32'd1));
    script.push_back(cfg_row(CFG_BASE, 32'h8000_0000));
    script.push_back(item_row(REQ_START, '0, 1'b1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_WRITE, 32'h8000_0000, 64'd1));
    script.push_back(result_row(REQ_ADVANCE, '0, KIND_READ, 32'h8000_0000, 64'd0));
    script.push_back(result_row(REQ_RDATA, 64'h8000_0000_0000_0001, KIND_FAIL,
                                32'h8000_0000, 64'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the script
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain_block();
        write_reg(script[i].code[0], cfg_data_t'(script[i].value));
      end else begin
        offer_item(script[i].code, script[i].value, got, res);
        if (script[i].typed) begin
          if (script[i].has_res) awaited_outcomes.push_back(script[i].want);
        end else if (got) begin
          awaited_outcomes.push_back(res);
        end
      end
    end

    // Random phases, each under a fresh register setting
    phase_no = 0;
    sent = 0;
    while (sent < 1200) begin
      drain_block();
      base_pick = $urandom_range(0, 7);
      if (base_pick == 0) new_base = '0;
      else if (base_pick == 1) new_base = 32'hFFFF_FFFF - $urandom_range(0, 15);
      else new_base = $urandom;
      count_pick = $urandom_range(0, 19);
      if (phase_no == 0 || count_pick == 0) new_count = 32'h0010_0000;
      else if (count_pick == 1) new_count = '0;
      else if (count_pick == 2) new_count = 32'd1;
      else if (count_pick == 3) new_count = {11'($urandom), 21'($urandom_range(1, 6))};
      else if (count_pick < 8) new_count = $urandom_range(1, 40);
      else new_count = $urandom_range(1, 6);
      write_reg(CFG_BASE, new_base);
      write_reg(CFG_COUNT, new_count);

      budget = $urandom_range(40, 120);
      tx_gap_pct = (phase_no % 3 == 1) ? 0 : $urandom_range(3, 20);
      rx_stall_pct = (phase_no % 4 == 3) ? 0 : $urandom_range(3, 20);
      if (phase_no == 2) begin
        // keep offering while the receiver holds off, so the block fills
        tx_gap_pct = 0;
        budget = 150;
        long_hold_req = 1'b1;
      end
      run_phase(budget);
      sent += budget;
      phase_no++;
    end

    // Last stretch at full rate on both sides
    drain_block();
    quiet = 1'b1;
    run_phase(150);
    drain_block();

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mpst_pkg.sv
rtl/core/mpst_front.sv
rtl/core/mpst_back.sv
rtl/core/memory_pattern_self_test.sv
rtl/core/mpst_checker.sv
tb/memory_pattern_self_test_test.sv
